// ----- rtl/core/lrp_pkg.sv -----
// Package for the LR table-driven parser: sizes, codes and the
// controller/datapath command and status bundles. No dependencies.
package lrp_pkg;

  localparam int STATES       = 256;
  localparam int TERMINALS    = 64;
  localparam int NONTERMINALS = 32;
  localparam int RULES        = 128;
  localparam int STACK_DEPTH  = 256;

  localparam int STATE_W = $clog2(STATES);
  localparam int TERM_W  = $clog2(TERMINALS);
  localparam int NT_W    = $clog2(NONTERMINALS);
  localparam int RULE_W  = $clog2(RULES);
  localparam int SP_W    = $clog2(STACK_DEPTH);
  localparam int CNT_W   = SP_W + 1;
  localparam int LEN_W   = 4;
  localparam int LIM_W   = 6;

  localparam int ACT_AW  = STATE_W + TERM_W;
  localparam int GOTO_AW = STATE_W + NT_W;
  localparam int ACT_DW  = 2 + STATE_W;
  localparam int GOTO_DW = 1 + STATE_W;
  localparam int RULE_DW = NT_W + LEN_W;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 6'd63;

  typedef enum logic [2:0] {
    CMD_ACT_WR  = 3'd0,
    CMD_GOTO_WR = 3'd1,
    CMD_RULE_WR = 3'd2,
    CMD_START   = 3'd3,
    CMD_TOKEN   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_ERROR  = 2'd0,
    ACT_SHIFT  = 2'd1,
    ACT_REDUCE = 2'd2,
    ACT_ACCEPT = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    K_REDUCE  = 4'd0,
    K_SHIFT   = 4'd1,
    K_ACCEPT  = 4'd2,
    K_NOACT   = 4'd3,
    K_NOGOTO  = 4'd4,
    K_UNDER   = 4'd5,
    K_OVER    = 4'd6,
    K_LIMIT   = 4'd7,
    K_ACK     = 4'd8,
    K_STARTED = 4'd9,
    K_IGNORED = 4'd10
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_ACC  = 2'd2,
    PH_REJ  = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_WRITE, ST_START, ST_IGNORE,
    ST_ACT_RD, ST_ACT_EV, ST_RULE_EV, ST_STK_EV, ST_GOTO_EV
  } state_t;

  typedef struct packed {
    logic  in_ready;
    logic  cap;
    logic  clr_step;
    logic  tbl_wr;
    logic  start;
    logic  red_clr;
    logic  act_rd;
    logic  rule_rd;
    logic  stk_rd;
    logic  goto_rd;
    logic  shift;
    logic  reduce;
    logic  accept;
    logic  reject;
    logic  emit;
    kind_t kind;
    logic  last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
    cmd_t cmd;
    logic run;
    act_t act_kind;
    logic rule_bad;
    logic limit_hit;
    logic count_zero;
    logic over_shift;
    logic underflow;
    logic goto_ok;
    logic over_red;
    logic wr_ok;
  } dp_stat_t;

endpackage

// ----- rtl/core/lrp_if.sv -----
// Request channel interfaces for the LR parser (input and result).
// Depends on lrp_pkg.
interface lrp_in_if import lrp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [2:0]          cmd;
  logic [STATE_W-1:0]  state_index;
  logic [TERM_W-1:0]   symbol;
  logic [1:0]          action_kind;
  logic [STATE_W-1:0]  target;
  logic                entry_valid;
  logic [RULE_W-1:0]   rule_index;
  logic [NT_W-1:0]     rule_lhs;
  logic [LEN_W-1:0]    rule_length;
  modport source (output valid, cmd, state_index, symbol, action_kind, target, entry_valid,
                  rule_index, rule_lhs, rule_length, input ready);
  modport sink (input valid, cmd, state_index, symbol, action_kind, target, entry_valid,
                rule_index, rule_lhs, rule_length, output ready);
endinterface

interface lrp_out_if import lrp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic [RULE_W-1:0]  rule_id;
  logic [STATE_W-1:0] top_state;
  logic [CNT_W-1:0]   depth;
  logic               last;
  modport source (output valid, kind, rule_id, top_state, depth, last, input ready);
  modport sink (input valid, kind, rule_id, top_state, depth, last, output ready);
endinterface

// ----- rtl/core/lrp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- rtl/core/lrp_ctrl.sv -----
// Parser controller: sequences table clear, writes and the per-token
// action/rule/stack/goto lookups. Depends on lrp_pkg.
module lrp_ctrl import lrp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  dp_stat_t  stat,
  output ctrl_cmd_t ctl
);
  state_t state, state_next;
  logic   term;     // token ends with this result
  logic   red_go;   // reduction completes
  kind_t  dec_kind;

  // outcome decode of the evaluation states
  always_comb begin
    term     = 1'b0;
    red_go   = 1'b0;
    dec_kind = K_REDUCE;
    case (state)
      ST_ACT_EV: begin
        if (stat.count_zero) begin
          term = 1'b1; dec_kind = K_UNDER;
        end else if (stat.act_kind == ACT_ERROR ||
                     (stat.act_kind == ACT_REDUCE && stat.rule_bad)) begin
          term = 1'b1; dec_kind = K_NOACT;
        end else if (stat.act_kind == ACT_ACCEPT) begin
          term = 1'b1; dec_kind = K_ACCEPT;
        end else if (stat.act_kind == ACT_SHIFT) begin
          term = 1'b1; dec_kind = stat.over_shift ? K_OVER : K_SHIFT;
        end else if (stat.limit_hit) begin
          term = 1'b1; dec_kind = K_LIMIT;
        end
      end
      ST_RULE_EV: begin
        if (stat.underflow) begin
          term = 1'b1; dec_kind = K_UNDER;
        end
      end
      ST_GOTO_EV: begin
        if (!stat.goto_ok) begin
          term = 1'b1; dec_kind = K_NOGOTO;
        end else if (stat.over_red) begin
          term = 1'b1; dec_kind = K_OVER;
        end else begin
          red_go = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (stat.clr_done) state_next = ST_IDLE;
      ST_IDLE:     if (in_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        case (stat.cmd)
          CMD_ACT_WR, CMD_GOTO_WR, CMD_RULE_WR: state_next = ST_WRITE;
          CMD_START: state_next = ST_START;
          CMD_TOKEN: state_next = stat.run ? ST_ACT_RD : ST_IGNORE;
          default:   state_next = ST_IGNORE;
        endcase
      end
      ST_WRITE, ST_START, ST_IGNORE: if (stat.out_free) state_next = ST_IDLE;
      ST_ACT_RD:   state_next = ST_ACT_EV;
      ST_ACT_EV: begin
        if (term) begin
          if (stat.out_free) state_next = ST_IDLE;
        end else begin
          state_next = ST_RULE_EV;
        end
      end
      ST_RULE_EV: begin
        if (term) begin
          if (stat.out_free) state_next = ST_IDLE;
        end else begin
          state_next = ST_STK_EV;
        end
      end
      ST_STK_EV:   state_next = ST_GOTO_EV;
      ST_GOTO_EV:  if (stat.out_free) state_next = term ? ST_IDLE : ST_ACT_RD;
      default:     state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    ctl      = '0;
    ctl.kind = K_REDUCE;
    case (state)
      ST_CLEAR: ctl.clr_step = 1'b1;
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
        ctl.cap      = in_valid;
      end
      ST_DISPATCH: ctl.red_clr = 1'b1;
      ST_WRITE: begin
        ctl.tbl_wr = stat.out_free & stat.wr_ok;
        ctl.emit   = stat.out_free;
        ctl.kind   = stat.wr_ok ? K_ACK : K_IGNORED;
        ctl.last   = 1'b1;
      end
      ST_START: begin
        ctl.start = stat.out_free;
        ctl.emit  = stat.out_free;
        ctl.kind  = K_STARTED;
        ctl.last  = 1'b1;
      end
      ST_IGNORE: begin
        ctl.emit = stat.out_free;
        ctl.kind = K_IGNORED;
        ctl.last = 1'b1;
      end
      ST_ACT_RD: ctl.act_rd = 1'b1;
      ST_STK_EV: ctl.goto_rd = 1'b1;
      ST_ACT_EV, ST_RULE_EV, ST_GOTO_EV: begin
        ctl.rule_rd = (state == ST_ACT_EV) & ~term;
        ctl.stk_rd  = (state == ST_RULE_EV) & ~term;
        if (term) begin
          ctl.emit   = stat.out_free;
          ctl.kind   = dec_kind;
          ctl.last   = 1'b1;
          ctl.shift  = stat.out_free & (dec_kind == K_SHIFT);
          ctl.accept = stat.out_free & (dec_kind == K_ACCEPT);
          ctl.reject = stat.out_free & (dec_kind != K_SHIFT) & (dec_kind != K_ACCEPT);
        end else if (red_go) begin
          ctl.emit   = stat.out_free;
          ctl.reduce = stat.out_free;
          ctl.kind   = K_REDUCE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ----- rtl/core/lrp_dp.sv -----
// Parser datapath: table RAMs, state stack, counters and result register.
// Depends on lrp_pkg, lrp_ram and the channel interfaces.
module lrp_dp import lrp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  lrp_in_if.sink           in_ch,
  lrp_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [LIM_W-1:0] cfg_wdata,
  input  ctrl_cmd_t        ctl,
  output dp_stat_t         stat
);
  // latched request
  cmd_t               r_cmd;
  logic [STATE_W-1:0] r_state;
  logic [TERM_W-1:0]  r_sym;
  logic [1:0]         r_akind;
  logic [STATE_W-1:0] r_tgt;
  logic               r_ev;
  logic [RULE_W-1:0]  r_ridx;
  logic [NT_W-1:0]    r_rlhs;
  logic [LEN_W-1:0]   r_rlen;

  // control state
  logic [CNT_W-1:0]   count;
  logic [STATE_W-1:0] top;
  phase_t             phase;
  logic [LIM_W-1:0]   limit;
  logic [LIM_W-1:0]   red;
  logic [ACT_AW-1:0]  clr_addr;

  // RAM read data
  logic [ACT_DW-1:0]  act_rdata;
  logic [GOTO_DW-1:0] goto_rdata;
  logic [RULE_DW-1:0] rule_rdata;
  logic [STATE_W-1:0] stk_rdata;

  logic [STATE_W-1:0] a_tgt, g_tgt;
  logic [LEN_W-1:0]   len;
  logic [NT_W-1:0]    lhs;
  logic [CNT_W-1:0]   after_pop;

  logic               act_we, goto_we, rule_we, stk_we;
  logic [ACT_AW-1:0]  act_waddr;
  logic [ACT_DW-1:0]  act_wdata;
  logic [GOTO_AW-1:0] goto_waddr;
  logic [GOTO_DW-1:0] goto_wdata;
  logic [SP_W-1:0]    stk_waddr;
  logic [STATE_W-1:0] stk_wdata;

  assign a_tgt     = act_rdata[STATE_W-1:0];
  assign g_tgt     = goto_rdata[STATE_W-1:0];
  assign len       = rule_rdata[LEN_W-1:0];
  assign lhs       = rule_rdata[RULE_DW-1:LEN_W];
  assign after_pop = count - CNT_W'(len);

  // status to the controller
  always_comb begin
    stat.clr_done   = (clr_addr == {ACT_AW{1'b1}});
    stat.out_free   = ~out_ch.valid | out_ch.ready;
    stat.cmd        = r_cmd;
    stat.run        = (phase == PH_RUN);
    stat.act_kind   = act_t'(act_rdata[ACT_DW-1:STATE_W]);
    stat.rule_bad   = (CNT_W'(a_tgt) >= CNT_W'(RULES));
    stat.limit_hit  = (red >= limit);
    stat.count_zero = (count == '0);
    stat.over_shift = (count >= CNT_W'(STACK_DEPTH));
    stat.underflow  = (count <= CNT_W'(len));
    stat.goto_ok    = goto_rdata[GOTO_DW-1];
    stat.over_red   = (after_pop >= CNT_W'(STACK_DEPTH));
    stat.wr_ok      = (r_cmd != CMD_GOTO_WR) ||
                      ({2'b00, r_sym} < (TERM_W + 2)'(NONTERMINALS));
  end

  // table write and clear muxing
  always_comb begin
    act_we     = ctl.clr_step | (ctl.tbl_wr & (r_cmd == CMD_ACT_WR));
    act_waddr  = ctl.clr_step ? clr_addr : {r_state, r_sym};
    act_wdata  = ctl.clr_step ? '0 : {r_akind, r_tgt};
    goto_we    = ctl.clr_step | (ctl.tbl_wr & (r_cmd == CMD_GOTO_WR));
    goto_waddr = ctl.clr_step ? clr_addr[GOTO_AW-1:0] : {r_state, r_sym[NT_W-1:0]};
    goto_wdata = ctl.clr_step ? '0 : {r_ev, r_tgt};
    rule_we    = ctl.tbl_wr & (r_cmd == CMD_RULE_WR);
    stk_we     = ctl.start | ctl.shift | ctl.reduce;
    if (ctl.start) begin
      stk_waddr = '0;
      stk_wdata = '0;
    end else if (ctl.shift) begin
      stk_waddr = count[SP_W-1:0];
      stk_wdata = a_tgt;
    end else begin
      stk_waddr = after_pop[SP_W-1:0];
      stk_wdata = g_tgt;
    end
  end

  lrp_ram #(.WIDTH(ACT_DW), .DEPTH(STATES * TERMINALS)) u_act (
    .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
    .re(ctl.act_rd), .raddr({top, r_sym}), .rdata(act_rdata)
  );

  lrp_ram #(.WIDTH(GOTO_DW), .DEPTH(STATES * NONTERMINALS)) u_goto (
    .clk(clk), .we(goto_we), .waddr(goto_waddr), .wdata(goto_wdata),
    .re(ctl.goto_rd), .raddr({stk_rdata, lhs}), .rdata(goto_rdata)
  );

  lrp_ram #(.WIDTH(RULE_DW), .DEPTH(RULES)) u_rule (
    .clk(clk), .we(rule_we), .waddr(r_ridx), .wdata({r_rlhs, r_rlen}),
    .re(ctl.rule_rd), .raddr(a_tgt[RULE_W-1:0]), .rdata(rule_rdata)
  );

  lrp_ram #(.WIDTH(STATE_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(ctl.stk_rd), .raddr(SP_W'(after_pop - CNT_W'(1))), .rdata(stk_rdata)
  );

  assign in_ch.ready = ctl.in_ready;

  // request capture
  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      r_cmd   <= cmd_t'(in_ch.cmd);
      r_state <= in_ch.state_index;
      r_sym   <= in_ch.symbol;
      r_akind <= in_ch.action_kind;
      r_tgt   <= in_ch.target;
      r_ev    <= in_ch.entry_valid;
      r_ridx  <= in_ch.rule_index;
      r_rlhs  <= in_ch.rule_lhs;
      r_rlen  <= in_ch.rule_length;
    end
  end

  // parser state, limit and clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      top      <= '0;
      phase    <= PH_IDLE;
      limit    <= LIMIT_RESET;
      red      <= '0;
      clr_addr <= '0;
    end else begin
      if (cfg_we) limit <= cfg_wdata;
      if (ctl.clr_step) clr_addr <= clr_addr + ACT_AW'(1);
      if (ctl.red_clr) red <= '0;
      if (ctl.start) begin
        count <= CNT_W'(1);
        top   <= '0;
        phase <= PH_RUN;
      end
      if (ctl.shift) begin
        count <= count + CNT_W'(1);
        top   <= a_tgt;
      end
      if (ctl.reduce) begin
        count <= after_pop + CNT_W'(1);
        top   <= g_tgt;
        red   <= red + LIM_W'(1);
      end
      if (ctl.accept) phase <= PH_ACC;
      if (ctl.reject) phase <= PH_REJ;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (ctl.emit) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_ch.kind    <= ctl.kind;
      out_ch.last    <= ctl.last;
      out_ch.rule_id <= ctl.reduce ? a_tgt[RULE_W-1:0] : '0;
      if (ctl.shift) begin
        out_ch.top_state <= a_tgt;
        out_ch.depth     <= count + CNT_W'(1);
      end else if (ctl.reduce) begin
        out_ch.top_state <= g_tgt;
        out_ch.depth     <= after_pop + CNT_W'(1);
      end else if (ctl.start) begin
        out_ch.top_state <= '0;
        out_ch.depth     <= CNT_W'(1);
      end else begin
        out_ch.top_state <= top;
        out_ch.depth     <= count;
      end
    end
  end
endmodule

// ----- rtl/core/lr_table_driven_parser_top.sv -----
// Top level of the LR table-driven parser: controller plus datapath.
// Depends on lrp_pkg, lrp_if, lrp_ctrl and lrp_dp.
//
//   channel  | dir | handshake          | payload
//   in_ch    | in  | valid/ready        | cmd, table write fields, token symbol
//   out_ch   | out | valid/ready        | kind, rule_id, top_state, depth, last
//   cfg      | in  | cfg_we             | cfg_wdata = reduction_limit
//
// A write, start or ignored request passes from dispatch to one emitting state. A token
// walks the chain of action, rule, stack and goto RAM reads, once per reduction,
// until an action read ends the token; an underflow can be found at the rule read,
// a goto miss or overflow at the goto read.
// After reset a clearing pass zeroes the action and goto tables; no request is
// taken then.
// A stalled result register holds the controller in its emitting state.
module lr_table_driven_parser_top import lrp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  lrp_in_if.sink           in_ch,
  lrp_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [LIM_W-1:0] cfg_wdata
);
  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  lrp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .stat(stat), .ctl(ctl)
  );

  lrp_dp u_dp (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .ctl(ctl), .stat(stat)
  );
endmodule

// ----- tb/sv/lr_table_driven_parser_top_tb.sv -----
// Self-checking testbench for lr_table_driven_parser_top: loads parse tables,
// runs directed and random token streams under varying back-pressure.
// Depends on lrp_pkg, lrp_if and the parser RTL.
module lr_table_driven_parser_top_tb import lrp_pkg::*; ();

  localparam int CYCLE_LIMIT = 2000000;
  localparam int N_RANDOM    = 240;

  typedef struct {
    bit [2:0] cmd;
    bit [7:0] st;
    bit [5:0] sym;
    bit [1:0] ak;
    bit [7:0] tgt;
    bit       ev;
    bit [6:0] ri;
    bit [4:0] rl;
    bit [3:0] len;
  } req_t;

  typedef struct {
    kind_t    kind;
    bit [6:0] rule;
    bit [7:0] top;
    bit [8:0] depth;
    bit       last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [LIM_W-1:0] cfg_wdata = '0;

  lrp_in_if  in_ch ();
  lrp_out_if out_ch ();

  lr_table_driven_parser_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Parser shadow: tables, stack and registers
  bit [1:0] sh_act_kind [STATES*TERMINALS];
  bit [7:0] sh_act_tgt  [STATES*TERMINALS];
  bit       sh_goto_ok  [STATES*NONTERMINALS];
  bit [7:0] sh_goto_tgt [STATES*NONTERMINALS];
  bit [4:0] sh_rule_lhs [RULES];
  bit [3:0] sh_rule_len [RULES];
  bit [7:0] sh_stack    [STACK_DEPTH];
  int       sh_count;
  phase_t   sh_phase;
  int       sh_limit;

  req_t    pending_reqs[$];
  result_t expected_results[$];
  int      send_idle_pct, stall_pct;
  int      mismatches, results_seen, cycles;

  function automatic req_t mk(bit [2:0] cmd, bit [7:0] st = '0, bit [5:0] sym = '0,
                              bit [1:0] ak = '0, bit [7:0] tgt = '0, bit ev = 1'b0,
                              bit [6:0] ri = '0, bit [4:0] rl = '0, bit [3:0] len = '0);
    req_t r;
    r.cmd = cmd; r.st = st; r.sym = sym; r.ak = ak; r.tgt = tgt; r.ev = ev;
    r.ri = ri; r.rl = rl; r.len = len;
    return r;
  endfunction

  function automatic void queue_req(req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic void push_result(kind_t k, int rule, bit last);
    result_t e;
    e.kind  = k;
    e.rule  = rule[6:0];
    e.top   = (sh_count == 0) ? 8'd0 : sh_stack[sh_count-1];
    e.depth = sh_count[8:0];
    e.last  = last;
    expected_results.insert(expected_results.size(), e);
  endfunction

  // One token: reduce until shift, accept or an error ends it
  function automatic void step_token(int sym);
    int reds, top, k, t, len, lhs, exposed, gix;
    reds = 0;
    while (1) begin
      if (sh_count == 0) begin
        sh_phase = PH_REJ; push_result(K_UNDER, 0, 1'b1); return;
      end
      top = int'(sh_stack[sh_count-1]);
      k = int'(sh_act_kind[top*TERMINALS + sym]);
      t = int'(sh_act_tgt[top*TERMINALS + sym]);
      if (k == ACT_ERROR || (k == ACT_REDUCE && t >= RULES)) begin
        sh_phase = PH_REJ; push_result(K_NOACT, 0, 1'b1); return;
      end
      if (k == ACT_ACCEPT) begin
        sh_phase = PH_ACC; push_result(K_ACCEPT, 0, 1'b1); return;
      end
      if (k == ACT_SHIFT) begin
        if (sh_count >= STACK_DEPTH) begin
          sh_phase = PH_REJ; push_result(K_OVER, 0, 1'b1); return;
        end
        sh_stack[sh_count] = t[7:0];
        sh_count++;
        push_result(K_SHIFT, 0, 1'b1);
        return;
      end
      len = int'(sh_rule_len[t]);
      lhs = int'(sh_rule_lhs[t]);
      if (reds >= sh_limit) begin
        sh_phase = PH_REJ; push_result(K_LIMIT, 0, 1'b1); return;
      end
      if (sh_count < len + 1) begin
        sh_phase = PH_REJ; push_result(K_UNDER, 0, 1'b1); return;
      end
      exposed = int'(sh_stack[sh_count-len-1]);
      gix = exposed*NONTERMINALS + lhs;
      if (!sh_goto_ok[gix]) begin
        sh_phase = PH_REJ; push_result(K_NOGOTO, 0, 1'b1); return;
      end
      if (sh_count - len >= STACK_DEPTH) begin
        sh_phase = PH_REJ; push_result(K_OVER, 0, 1'b1); return;
      end
      sh_count -= len;
      sh_stack[sh_count] = sh_goto_tgt[gix];
      sh_count++;
      reds++;
      push_result(K_REDUCE, t, 1'b0);
    end
  endfunction

  function automatic void predict_request(req_t r);
    case (r.cmd)
      CMD_ACT_WR: begin
        sh_act_kind[r.st*TERMINALS + r.sym] = r.ak;
        sh_act_tgt[r.st*TERMINALS + r.sym]  = r.tgt;
        push_result(K_ACK, 0, 1'b1);
      end
      CMD_GOTO_WR: begin
        if (r.sym >= NONTERMINALS) push_result(K_IGNORED, 0, 1'b1);
        else begin
          sh_goto_ok[r.st*NONTERMINALS + r.sym]  = r.ev;
          sh_goto_tgt[r.st*NONTERMINALS + r.sym] = r.tgt;
          push_result(K_ACK, 0, 1'b1);
        end
      end
      CMD_RULE_WR: begin
        sh_rule_lhs[r.ri] = r.rl;
        sh_rule_len[r.ri] = r.len;
        push_result(K_ACK, 0, 1'b1);
      end
      CMD_START: begin
        sh_stack[0] = 8'd0;
        sh_count = 1;
        sh_phase = PH_RUN;
        push_result(K_STARTED, 0, 1'b1);
      end
      CMD_TOKEN: begin
        if (sh_phase != PH_RUN) push_result(K_IGNORED, 0, 1'b1);
        else step_token(int'(r.sym));
      end
      default: push_result(K_IGNORED, 0, 1'b1);
    endcase
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d expected %0d",
             results_seen, what, got, want);
    mismatches++;
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_t r;
        r = pending_reqs.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= r.cmd;
        in_ch.state_index <= r.st;
        in_ch.symbol      <= r.sym;
        in_ch.action_kind <= r.ak;
        in_ch.target      <= r.tgt;
        in_ch.entry_valid <= r.ev;
        in_ch.rule_index  <= r.ri;
        in_ch.rule_lhs    <= r.rl;
        in_ch.rule_length <= r.len;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result back-pressure
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      predict_request(mk(in_ch.cmd, in_ch.state_index, in_ch.symbol, in_ch.action_kind,
                         in_ch.target, in_ch.entry_valid, in_ch.rule_index,
                         in_ch.rule_lhs, in_ch.rule_length));
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report("unexpected result kind", int'(out_ch.kind), -1);
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (out_ch.kind !== e.kind) report("kind", int'(out_ch.kind), int'(e.kind));
        if (out_ch.rule_id !== e.rule) report("rule_id", int'(out_ch.rule_id), int'(e.rule));
        if (out_ch.top_state !== e.top)
          report("top_state", int'(out_ch.top_state), int'(e.top));
        if (out_ch.depth !== e.depth) report("depth", int'(out_ch.depth), int'(e.depth));
        if (out_ch.last !== e.last) report("last", int'(out_ch.last), int'(e.last));
      end
      results_seen++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_limit(int v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v[LIM_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_limit = v;
  endtask

  // Reduce targets stay on written rules (0..7) or beyond the rule table
  function automatic bit [7:0] random_tgt();
    if ($urandom_range(7) == 0) return 8'(128 + $urandom_range(127));
    return 8'($urandom_range(7));
  endfunction

  // Random grammar traffic, mostly over states 0..7 and terminals 0..5
  function automatic req_t random_req();
    int p;
    p = int'($urandom_range(99));
    if (p < 12) return mk(CMD_START);
    if (p < 70) return mk(CMD_TOKEN, 8'd0, ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                                                     : 6'($urandom_range(5)));
    if (p < 80) return mk(CMD_ACT_WR, 8'($urandom_range(7)), 6'($urandom_range(5)),
                          2'($urandom_range(3)), random_tgt());
    if (p < 88) return mk(CMD_GOTO_WR, 8'($urandom_range(7)), 6'($urandom_range(3)), 2'd0,
                          8'($urandom_range(7)), $urandom_range(5) != 0);
    if (p < 93) return mk(CMD_RULE_WR, 8'd0, 6'd0, 2'd0, 8'd0, 1'b0, 7'($urandom_range(7)),
                          5'($urandom_range(3)), 4'($urandom_range(3)));
    if (p < 96) return mk(CMD_GOTO_WR, 8'($urandom_range(255)), 6'(32 + $urandom_range(31)),
                          2'd0, 8'($urandom_range(255)), 1'($urandom_range(1)));
    if (p < 98) return mk(3'(5 + $urandom_range(2)), 8'($urandom_range(255)),
                          6'($urandom_range(63)), 2'($urandom_range(3)),
                          8'($urandom_range(255)), 1'($urandom_range(1)),
                          7'($urandom_range(127)), 5'($urandom_range(31)),
                          4'($urandom_range(15)));
    return mk(CMD_ACT_WR, 8'($urandom_range(255)), 6'($urandom_range(63)),
              2'($urandom_range(3)), random_tgt());
  endfunction

  initial begin
    int idle_mode [4];
    int stall_mode[4];
    int limits    [4];
    int k;
    idle_mode  = '{0, 77, 0, 32};
    stall_mode = '{0, 0, 77, 32};
    limits     = '{63, 1, 0, 5};
    limits[3]  = 2 + int'($urandom_range(60));
    in_ch.valid = 1'b0;
    in_ch.cmd = '0; in_ch.state_index = '0; in_ch.symbol = '0; in_ch.action_kind = '0;
    in_ch.target = '0; in_ch.entry_valid = 1'b0; in_ch.rule_index = '0;
    in_ch.rule_lhs = '0; in_ch.rule_length = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0; stall_pct = 0;
    mismatches = 0; results_seen = 0; cycles = 0;
    foreach (sh_act_kind[i]) begin sh_act_kind[i] = 0; sh_act_tgt[i] = 0; end
    foreach (sh_goto_ok[i]) begin sh_goto_ok[i] = 0; sh_goto_tgt[i] = 0; end
    sh_count = 0; sh_phase = PH_IDLE; sh_limit = 63;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Every rule that can be reduced gets written; high rules drive the directed cases
    for (int r = 0; r < 8; r++)
      queue_req(mk(CMD_RULE_WR, 8'd0, 6'd0, 2'd0, 8'd0, 1'b0, 7'(r),
                   5'($urandom_range(3)), 4'($urandom_range(3))));
    queue_req(mk(CMD_RULE_WR, 8'd0, 6'd0, 2'd0, 8'd0, 1'b0, 7'd127, 5'd31, 4'd0));
    queue_req(mk(CMD_RULE_WR, 8'd0, 6'd0, 2'd0, 8'd0, 1'b0, 7'd126, 5'd0, 4'd15));
    queue_req(mk(CMD_RULE_WR, 8'd0, 6'd0, 2'd0, 8'd0, 1'b0, 7'd125, 5'd1, 4'd0));
    queue_req(mk(CMD_RULE_WR, 8'd0, 6'd0, 2'd0, 8'd0, 1'b0, 7'd124, 5'd30, 4'd0));
    // Small random grammar
    for (int s = 0; s < 8; s++) begin
      for (int t = 0; t < 6; t++) begin
        k = int'($urandom_range(99));
        queue_req(mk(CMD_ACT_WR, 8'(s), 6'(t),
          (k < 20) ? ACT_ERROR : (k < 60) ? ACT_SHIFT : (k < 95) ? ACT_REDUCE : ACT_ACCEPT,
          8'($urandom_range(7))));
      end
      for (int n = 0; n < 4; n++)
        queue_req(mk(CMD_GOTO_WR, 8'(s), 6'(n), 2'd0, 8'($urandom_range(7)),
                     $urandom_range(6) != 0));
    end

    // Directed: ignored requests, special table entries, each error path
    queue_req(mk(CMD_TOKEN, 8'd0, 6'd63));
    for (int c = 5; c < 8; c++)
      queue_req(mk(c[2:0], 8'd255, 6'd63, 2'd3, 8'd255, 1'b1, 7'd127, 5'd31, 4'd15));
    queue_req(mk(CMD_GOTO_WR, 8'd255, 6'd32, 2'd0, 8'd255, 1'b1));
    queue_req(mk(CMD_GOTO_WR, 8'd255, 6'd0, 2'd0, 8'd0, 1'b0));
    queue_req(mk(CMD_GOTO_WR, 8'd255, 6'd31, 2'd0, 8'd255, 1'b1));
    queue_req(mk(CMD_GOTO_WR, 8'd1, 6'd1, 2'd0, 8'd1, 1'b1));
    queue_req(mk(CMD_ACT_WR, 8'd0, 6'd63, ACT_SHIFT, 8'd255));
    queue_req(mk(CMD_ACT_WR, 8'd255, 6'd63, ACT_SHIFT, 8'd255));
    queue_req(mk(CMD_ACT_WR, 8'd255, 6'd62, ACT_REDUCE, 8'd127));
    queue_req(mk(CMD_ACT_WR, 8'd0, 6'd61, ACT_REDUCE, 8'd126));
    queue_req(mk(CMD_ACT_WR, 8'd0, 6'd59, ACT_REDUCE, 8'd200));
    queue_req(mk(CMD_ACT_WR, 8'd0, 6'd58, ACT_ACCEPT, 8'd0));
    queue_req(mk(CMD_ACT_WR, 8'd0, 6'd57, ACT_REDUCE, 8'd124));
    queue_req(mk(CMD_ACT_WR, 8'd0, 6'd56, ACT_SHIFT, 8'd1));
    queue_req(mk(CMD_ACT_WR, 8'd1, 6'd60, ACT_REDUCE, 8'd125));
    // accept, then token after accept is ignored
    queue_req(mk(CMD_START));
    queue_req(mk(CMD_TOKEN, 8'd0, 6'd58));
    queue_req(mk(CMD_TOKEN, 8'd0, 6'd58));
    // underflow, rule out of range, missing goto
    queue_req(mk(CMD_START));
    queue_req(mk(CMD_TOKEN, 8'd0, 6'd61));
    queue_req(mk(CMD_START));
    queue_req(mk(CMD_TOKEN, 8'd0, 6'd59));
    queue_req(mk(CMD_START));
    queue_req(mk(CMD_TOKEN, 8'd0, 6'd57));
    // epsilon loop runs into the reduction limit at 63, then at 1
    queue_req(mk(CMD_START));
    queue_req(mk(CMD_TOKEN, 8'd0, 6'd56));
    queue_req(mk(CMD_TOKEN, 8'd0, 6'd60));
    set_limit(63);
    queue_req(mk(CMD_START));
    queue_req(mk(CMD_TOKEN, 8'd0, 6'd56));
    queue_req(mk(CMD_TOKEN, 8'd0, 6'd60));
    set_limit(1);
    queue_req(mk(CMD_START));
    queue_req(mk(CMD_TOKEN, 8'd0, 6'd56));
    queue_req(mk(CMD_TOKEN, 8'd0, 6'd60));
    // chain of seven epsilon reductions through states 200..207, then a shift
    // back to 200: each token grows the stack by eight until a reduce overflows
    set_limit(63);
    queue_req(mk(CMD_ACT_WR, 8'd0, 6'd54, ACT_SHIFT, 8'd200));
    for (int j = 0; j < 7; j++) begin
      queue_req(mk(CMD_ACT_WR, 8'(200 + j), 6'd54, ACT_REDUCE, 8'd127));
      queue_req(mk(CMD_GOTO_WR, 8'(200 + j), 6'd31, 2'd0, 8'(201 + j), 1'b1));
    end
    queue_req(mk(CMD_ACT_WR, 8'd207, 6'd54, ACT_SHIFT, 8'd200));
    queue_req(mk(CMD_START));
    repeat (33) queue_req(mk(CMD_TOKEN, 8'd0, 6'd54));
    drain();

    // Random phases under each back-pressure pattern and limit
    for (int ph = 0; ph < 4; ph++) begin
      set_limit(limits[ph]);
      send_idle_pct = idle_mode[ph];
      stall_pct     = stall_mode[ph];
      for (int i = 0; i < N_RANDOM / 4; i++) queue_req(random_req());
      drain();
    end

    $display("checked %0d results from directed and random requests", results_seen);
    $display("four back-pressure patterns, reduction limits 0 to 63, %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
